// ===== sv/adpcm_fd_pkg.sv =====
package adpcm_fd_pkg;

   localparam int NUM_PREDICTORS = 8;
   localparam int PRED_BITS      = $clog2(NUM_PREDICTORS);
   localparam int FRAME_BYTES    = 8;
   localparam int POS_BITS       = $clog2(FRAME_BYTES);
   localparam int COEF_BITS      = 16;
   localparam int SAMPLE_BITS    = 16;
   localparam int SHIFT_BITS     = 4;
   localparam int FRAC_BITS      = 11;
   localparam int ACC_BITS       = 34;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = PRED_BITS + 2;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'h7fff;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'h8000;
   localparam logic signed [ACC_BITS-1:0] ROUND_BIAS = 34'sd1024;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   typedef logic [CSR_DATA_BITS-1:0] coef_array_type [NUM_PREDICTORS];

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HI,
      ST_LO
   } ctrl_state_type;

   typedef struct packed {
      logic load_hist;
      logic take_header;
      logic take_byte;
      logic step_hi;
      logic step_lo;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ===== sv/adpcm_fd_regs.sv =====
module adpcm_fd_regs (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [adpcm_fd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [adpcm_fd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [adpcm_fd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                     csr_pready,
   output adpcm_fd_pkg::coef_array_type             coef
);
   import adpcm_fd_pkg::*;

   coef_array_type coef_ff;
   logic [PRED_BITS-1:0] reg_index;
   logic wr_en;

   assign reg_index  = csr_paddr[CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = coef_ff[reg_index];
   assign coef       = coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PREDICTORS; i++) coef_ff[i] <= '0;
      end else if (wr_en) begin
         coef_ff[reg_index] <= csr_pwdata;
      end
   end

endmodule

// ===== sv/adpcm_fd_ctrl.sv =====
module adpcm_fd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_func,
   output logic                        req_tready,
   input  adpcm_fd_pkg::dp_status_type status,
   output adpcm_fd_pkg::dp_cmd_type    cmd
);
   import adpcm_fd_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic accept;
   logic is_load, is_header;

   assign is_load   = (req_func == FUNC_LOAD);
   assign is_header = !is_load && (pos_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_HI: begin
            if (status.out_free) begin
               cmd.step_hi = 1'b1;
               state_in    = ST_LO;
            end
         end
         ST_LO: begin
            // take the next transaction in the cycle the low sample is placed
            if (status.out_free) begin
               cmd.step_lo = 1'b1;
               req_tready  = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      accept = req_tvalid & req_tready;
      pos_in = pos_ff;
      if (accept) begin
         if (is_load) begin
            cmd.load_hist = 1'b1;
            pos_in        = '0;
         end else if (is_header) begin
            cmd.take_header = 1'b1;
            pos_in          = POS_BITS'(1);
         end else begin
            cmd.take_byte = 1'b1;
            state_in      = ST_HI;
            pos_in        = (pos_ff == POS_BITS'(FRAME_BYTES - 1)) ? '0 : pos_ff + 1'b1;
         end
      end
   end

endmodule

// ===== sv/adpcm_fd_datapath.sv =====
module adpcm_fd_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  adpcm_fd_pkg::dp_cmd_type               cmd,
   output adpcm_fd_pkg::dp_status_type            status,
   input  adpcm_fd_pkg::coef_array_type           coef,
   input  logic [7:0]                             data_byte,
   input  logic signed [adpcm_fd_pkg::SAMPLE_BITS-1:0] load_recent,
   input  logic signed [adpcm_fd_pkg::SAMPLE_BITS-1:0] load_older,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic signed [adpcm_fd_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                   rsp_last
);
   import adpcm_fd_pkg::*;

   logic signed [SAMPLE_BITS-1:0] hist_recent_ff, hist_older_ff;
   logic [PRED_BITS-1:0]          pred_ff;
   logic [SHIFT_BITS-1:0]         shift_ff;
   logic [7:0]                    byte_ff;
   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic                          out_last_ff;

   logic [CSR_DATA_BITS-1:0]      pair;
   logic signed [COEF_BITS-1:0]   c1, c2;
   logic [3:0]                    nib;
   logic [SHIFT_BITS:0]           scale_amt;
   logic signed [ACC_BITS-1:0]    scaled;
   logic signed [2*COEF_BITS-1:0] prod1, prod2;
   logic signed [ACC_BITS-1:0]    acc;
   logic [ACC_BITS-FRAC_BITS-1:0] quot;
   logic signed [SAMPLE_BITS-1:0] sat_in;
   logic                          step;

   assign pair  = coef[pred_ff];
   assign c1    = $signed(pair[COEF_BITS-1:0]);
   assign c2    = $signed(pair[2*COEF_BITS-1:COEF_BITS]);
   assign step  = cmd.step_hi | cmd.step_lo;
   assign nib   = cmd.step_lo ? byte_ff[3:0] : byte_ff[7:4];
   assign prod1 = c1 * hist_recent_ff;
   assign prod2 = c2 * hist_older_ff;

   always_comb begin
      scale_amt = {1'b0, shift_ff} + (SHIFT_BITS + 1)'(FRAC_BITS);
      scaled    = $signed({{(ACC_BITS-4){nib[3]}}, nib}) <<< scale_amt;
      acc       = scaled + ROUND_BIAS
                + $signed({{(ACC_BITS-2*COEF_BITS){prod1[2*COEF_BITS-1]}}, prod1})
                + $signed({{(ACC_BITS-2*COEF_BITS){prod2[2*COEF_BITS-1]}}, prod2});
      // arithmetic shift keeps floor rounding for negative sums
      quot      = acc[ACC_BITS-1:FRAC_BITS];
      if (quot[ACC_BITS-FRAC_BITS-1:SAMPLE_BITS-1]
            == {(ACC_BITS-FRAC_BITS-SAMPLE_BITS+1){quot[SAMPLE_BITS-1]}}) begin
         sat_in = $signed(quot[SAMPLE_BITS-1:0]);
      end else if (quot[ACC_BITS-FRAC_BITS-1]) begin
         sat_in = $signed(SAMPLE_MIN);
      end else begin
         sat_in = $signed(SAMPLE_MAX);
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_recent_ff <= '0;
         hist_older_ff  <= '0;
         pred_ff        <= '0;
         shift_ff       <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         // a load landing with the low sample overrides its history update
         if (cmd.load_hist) begin
            hist_recent_ff <= load_recent;
            hist_older_ff  <= load_older;
         end else if (step) begin
            hist_recent_ff <= sat_in;
            hist_older_ff  <= hist_recent_ff;
         end
         if (cmd.take_header) begin
            pred_ff  <= data_byte[PRED_BITS+3:4];
            shift_ff <= data_byte[SHIFT_BITS-1:0];
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte) byte_ff <= data_byte;
      if (step) begin
         out_sample_ff <= sat_in;
         out_last_ff   <= cmd.step_lo;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_sample = out_sample_ff;
   assign rsp_last   = out_last_ff;

endmodule

// ===== sv/adpcm_frame_decoder_core.sv =====
// DSP-ADPCM frame decoder, one frame byte per req transaction.
// req channel: tuser = 0 carries a frame byte in tdata[7:0]; tuser = 1 loads
// the history from tdata[23:8] (recent) and tdata[39:24] (older) and makes
// the next byte a frame header. A header byte selects one of eight
// coefficient pairs (csr port, register n at byte address 4*n) and the scale
// shift; header and load transactions give no result.
// Each later byte gives two rsp transactions: the high-nibble sample with
// tlast = 0, then the low-nibble sample with tlast = 1.
// The byte is registered when accepted; state ST_HI then places the high
// sample in the output register and state ST_LO the low one. A single
// saturating multiply-accumulate serves both samples, and the second needs
// the first as history, so no new data byte is taken before the low sample
// is placed; header and load transactions leave the decoder idle.
// When rsp stalls, the sample holds in the output register and the decoder
// waits; the next byte is taken in the cycle the low sample is placed.
// Reset (synchronous) clears history, predictor, shift, frame position and
// all coefficient registers, and drops any pending result.
module adpcm_frame_decoder_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [7:0] data_byte, [23:8] load_recent, [39:24] load_older
   input  logic [39:0]                            req_tdata,
   // [0] func
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [15:0] sample
   output logic [adpcm_fd_pkg::SAMPLE_BITS-1:0]   rsp_tdata,
   output logic                                   rsp_tlast,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [adpcm_fd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [adpcm_fd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [adpcm_fd_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                   csr_pready
);
   import adpcm_fd_pkg::*;

   coef_array_type coef;
   dp_cmd_type     cmd;
   dp_status_type  status;
   logic signed [SAMPLE_BITS-1:0] rsp_sample;

   adpcm_fd_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   adpcm_fd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   adpcm_fd_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .coef        (coef),
      .data_byte   (req_tdata[7:0]),
      .load_recent ($signed(req_tdata[23:8])),
      .load_older  ($signed(req_tdata[39:24])),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_sample  (rsp_sample),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = rsp_sample;

endmodule

// ===== sv/adpcm_fd_checker.sv =====
module adpcm_fd_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_tready,
   input logic                                   rsp_tvalid,
   input logic                                   rsp_tready,
   input logic [adpcm_fd_pkg::SAMPLE_BITS-1:0]   rsp_tdata,
   input logic                                   rsp_tlast
);

   // pending result is dropped by reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp transaction changed");

   // low sample follows the high sample right after it is taken
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("low-nibble sample did not follow high-nibble sample");

   // while a high sample waits, a new byte is taken only as it leaves
   a_req_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> req_tready == rsp_tready)
      else $error("req_tready not tied to high sample draining");

endmodule

bind adpcm_frame_decoder_core adpcm_fd_checker u_adpcm_fd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
